// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the starfield generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/lsg_pkg.sv =====
// ----------------------------------------------------------------------------
// lsg_pkg
// Types, raster constants and register indexes for the starfield generator.
// ----------------------------------------------------------------------------
package lsg_pkg;

  // Raster geometry.
  localparam int SCREEN_COLS = 288;
  localparam int SCREEN_ROWS = 224;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 8;
  localparam int LFSR_W      = 16;
  localparam int PEN_W       = 6;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);

  // Star pattern constants.
  localparam logic [LFSR_W-1:0] PAT_BASE = 16'h3fc0;
  localparam logic [LFSR_W-1:0] PAT_MASK = 16'hffc0;
  localparam int                PAT_A_BIT = 14;
  localparam int                PAT_B_BIT = 15;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_STARS_ENABLE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK_START = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SET_A_SELECT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SET_B_SELECT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LFSR_SEED      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_MIN_ROW   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_MAX_ROW   = 3'd6;

  localparam logic [ROW_W-1:0] CLIP_MAX_RESET = 8'd223;

  // Configuration register file contents.
  typedef struct packed {
    logic              stars_enable;
    logic              feedback_start;
    logic              set_a_select;
    logic              set_b_select;
    logic [LFSR_W-1:0] lfsr_seed;
    logic [ROW_W-1:0]  clip_min_row;
    logic [ROW_W-1:0]  clip_max_row;
  } lsg_cfg_t;

  // Star decision for one pixel.
  typedef struct packed {
    logic             write;
    logic [PEN_W-1:0] pen;
  } lsg_star_t;

endpackage

// ===== design/lsg_star_unit.sv =====
// ----------------------------------------------------------------------------
// lsg_star_unit
// One LFSR step with star pattern match and row clipping.
// ----------------------------------------------------------------------------
module lsg_star_unit (
  input  lsg_pkg::lsg_cfg_t                cfg_i,
  input  logic                             active_i,
  input  logic [lsg_pkg::LFSR_W-1:0]       shift_i,
  input  logic                             feedback_i,
  input  logic [lsg_pkg::ROW_W-1:0]        row_i,
  output logic [lsg_pkg::LFSR_W-1:0]       shift_o,
  output logic                             feedback_o,
  output lsg_pkg::lsg_star_t               star_o
);

  logic                        step;
  logic                        new_bit;
  logic [lsg_pkg::LFSR_W-1:0]  stepped;
  logic [lsg_pkg::LFSR_W-1:0]  top;
  logic [lsg_pkg::LFSR_W-1:0]  pat_a;
  logic [lsg_pkg::LFSR_W-1:0]  pat_b;
  logic                        hit;
  logic                        in_clip;

  // The LFSR only advances inside a frame with the starfield on.
  assign step    = active_i & cfg_i.stars_enable;
  assign new_bit = ~(shift_i[4] ^ feedback_i);
  assign stepped = {shift_i[lsg_pkg::LFSR_W-2:0], new_bit};

  assign shift_o    = step ? stepped : shift_i;
  assign feedback_o = step ? shift_i[lsg_pkg::LFSR_W-1] : feedback_i;

  // Compare the upper ten bits against both star patterns.
  always_comb begin
    pat_a = lsg_pkg::PAT_BASE;
    pat_b = lsg_pkg::PAT_BASE;
    pat_a[lsg_pkg::PAT_A_BIT] = cfg_i.set_a_select;
    pat_b[lsg_pkg::PAT_B_BIT] = cfg_i.set_b_select;
  end

  assign top     = stepped & lsg_pkg::PAT_MASK;
  assign hit     = (top == pat_a) || (top == pat_b);
  assign in_clip = (row_i >= cfg_i.clip_min_row) && (row_i <= cfg_i.clip_max_row);

  assign star_o.write = step & hit & in_clip;
  assign star_o.pen   = star_o.write ? stepped[lsg_pkg::PEN_W-1:0] : '0;

endmodule

// ===== design/lfsr_starfield_generator.sv =====
// A result appears on the master side in the cycle after its tick is accepted.
// One tick per cycle when not stalled; LFSR and raster registers update in one pass.
// The slave side stays ready while the result register is empty or being drained.
// Reset clears the LFSR, feedback bit, raster position, frame flag and valid flag;
// configuration resets to zero except the last clip row, which resets to 223.
// ----------------------------------------------------------------------------
// lfsr_starfield_generator
// Per-pixel starfield generator driven by an LFSR over a fixed raster.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfsr_starfield_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [lsg_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [lsg_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // Tick stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [0] frame_start, rest zero
  // Pixel stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [8:0] pixel_x, [16:9] pixel_y, [17] star_write, [23:18] star_pen
  output logic [23:0]                         m_axis_tdata,
  output logic                                m_axis_tlast
);

  lsg_pkg::lsg_cfg_t              cfg_q;
  logic [lsg_pkg::LFSR_W-1:0]     shift_q, shift_d, shift_cur;
  logic                           feedback_q, feedback_d, feedback_cur;
  logic [lsg_pkg::COL_W-1:0]      col_q, col_d, col_cur;
  logic [lsg_pkg::ROW_W-1:0]      row_q, row_d, row_cur;
  logic                           active_q, active_d, active_cur;
  logic                           frame_start;
  logic                           accept;
  logic                           last;
  lsg_pkg::lsg_star_t             star;

  logic                           out_valid_q;
  logic [23:0]                    out_data_q;
  logic                           out_last_q;

  logic                           chk_idle;
  logic                           chk_hold;
  logic                           chk_no_star;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0, lsg_pkg::CLIP_MAX_RESET};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lsg_pkg::CFG_STARS_ENABLE:   cfg_q.stars_enable   <= cfg_wdata_i[0];
        lsg_pkg::CFG_FEEDBACK_START: cfg_q.feedback_start <= cfg_wdata_i[0];
        lsg_pkg::CFG_SET_A_SELECT:   cfg_q.set_a_select   <= cfg_wdata_i[0];
        lsg_pkg::CFG_SET_B_SELECT:   cfg_q.set_b_select   <= cfg_wdata_i[0];
        lsg_pkg::CFG_LFSR_SEED:      cfg_q.lfsr_seed      <= cfg_wdata_i;
        lsg_pkg::CFG_CLIP_MIN_ROW:   cfg_q.clip_min_row   <= cfg_wdata_i[lsg_pkg::ROW_W-1:0];
        lsg_pkg::CFG_CLIP_MAX_ROW:   cfg_q.clip_max_row   <= cfg_wdata_i[lsg_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: take a tick whenever the result register is free or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign frame_start   = s_axis_tdata[0];

  // A frame start reloads the state before the pixel is processed.
  assign shift_cur    = frame_start ? cfg_q.lfsr_seed : shift_q;
  assign feedback_cur = frame_start ? cfg_q.feedback_start : feedback_q;
  assign col_cur      = frame_start ? '0 : col_q;
  assign row_cur      = frame_start ? '0 : row_q;
  assign active_cur   = frame_start | active_q;

  lsg_star_unit u_star (
    .cfg_i      (cfg_q),
    .active_i   (active_cur),
    .shift_i    (shift_cur),
    .feedback_i (feedback_cur),
    .row_i      (row_cur),
    .shift_o    (shift_d),
    .feedback_o (feedback_d),
    .star_o     (star)
  );

  // Raster position advance.
  assign last = active_cur && (col_cur == lsg_pkg::COL_LAST) && (row_cur == lsg_pkg::ROW_LAST);

  always_comb begin
    col_d    = col_cur;
    row_d    = row_cur;
    active_d = active_cur;
    if (active_cur) begin
      priority if (last) begin
        col_d    = '0;
        row_d    = '0;
        active_d = 1'b0;
      end else if (col_cur >= lsg_pkg::COL_LAST) begin
        col_d = '0;
        row_d = row_cur + lsg_pkg::ROW_W'(1);
      end else begin
        col_d = col_cur + lsg_pkg::COL_W'(1);
      end
    end
  end

  // State registers advance on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q    <= '0;
      feedback_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      active_q   <= 1'b0;
    end else if (accept) begin
      shift_q    <= shift_d;
      feedback_q <= feedback_d;
      col_q      <= col_d;
      row_q      <= row_d;
      active_q   <= active_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {star.pen, star.write, row_cur, col_cur};
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Conditions watched by the checks below.
  assign chk_idle    = accept && !active_q && !frame_start;
  assign chk_hold    = accept && !frame_start && !cfg_q.stars_enable;
  assign chk_no_star = out_valid_q && !out_data_q[17];

  // Checks on the frame and LFSR control.
  `ASSERT_IMPLIES_NEXT(a_last_ends_frame, clk_i, rst_ni, accept && last, !active_q)
  `ASSERT_IMPLIES_NEXT(a_idle_pixel_zero, clk_i, rst_ni, chk_idle, m_axis_tdata == 24'd0 && !m_axis_tlast)
  `ASSERT_IMPLIES_NEXT(a_lfsr_holds_disabled, clk_i, rst_ni, chk_hold, shift_q == $past(shift_q))
  `ASSERT_IMPLIES(a_pen_zero_no_star, clk_i, rst_ni, chk_no_star, out_data_q[23:18] == 6'd0)

endmodule
